// ----- src/sdtp_pkg.sv -----
// Shared types and constants for the signed decimal text placer.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package sdtp_pkg;

	localparam int MAX_DIGITS_DEFAULT = 10;
	localparam int QUEUE_DEPTH        = 2;
	localparam int TOTAL_W            = 4;

	localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
	localparam logic [6:0]  CHAR_ZERO  = 7'd48;
	localparam logic [6:0]  CHAR_MINUS = 7'd45;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_DIV,
		FR_PUSH
	} front_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		logic [7:0] column;
		logic [7:0] row;
		logic       neg;
	} job_head_t;

endpackage

// ----- src/sdtp_if.sv -----
// Channel interfaces for the number input and the character output.
// No dependencies.
`timescale 1ns / 1ps

interface sdtp_in_if;
	logic               valid;
	logic               ready;
	logic        [7:0]  cell_column;
	logic        [7:0]  cell_row;
	logic signed [31:0] value;

	modport source (output valid, cell_column, cell_row, value, input ready);
	modport sink   (input valid, cell_column, cell_row, value, output ready);
endinterface

interface sdtp_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic [7:0] out_column;
	logic [7:0] out_row;
	logic       visible;
	logic [3:0] total_length;
	logic       last;

	modport source (output valid, char_code, out_column, out_row, visible, total_length, last,
		input ready);
	modport sink   (input valid, char_code, out_column, out_row, visible, total_length, last,
		output ready);
endinterface

// ----- src/sdtp_front.sv -----
// Front part: accepts a number and splits its magnitude into decimal digits.
// Depends on sdtp_pkg and sdtp_in_if; hands a packed job to the queue.
`timescale 1ns / 1ps

module sdtp_front import sdtp_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	sdtp_in_if.sink             num,
	output logic                job_valid,
	input  logic                job_ready,
	output logic [8+8+1+$clog2(MAX_DIGITS+1)+4*MAX_DIGITS-1:0] job_data
);

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int IW = $clog2(MAX_DIGITS);

	front_state_t state_q, state_d;

	job_head_t         head_q;
	logic [31:0]       mag_q;
	logic [63:0]       prod_q;
	logic [CW-1:0]     cnt_q;
	logic [3:0]        digits_q [MAX_DIGITS];
	logic [31:0]       quo;
	logic [31:0]       rem;
	logic [4*MAX_DIGITS-1:0] digits_flat;

	assign quo = {3'b000, prod_q[63:35]};
	assign rem = mag_q - (quo << 3) - (quo << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		num.ready = 1'b0;
		job_valid = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				num.ready = 1'b1;
				if (num.valid) begin
					state_d = FR_MUL;
				end
			end
			FR_MUL: begin
				state_d = FR_DIV;
			end
			FR_DIV: begin
				if (quo == 32'd0 || cnt_q == CW'(MAX_DIGITS - 1)) begin
					state_d = FR_PUSH;
				end else begin
					state_d = FR_MUL;
				end
			end
			FR_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FR_IDLE: begin
				if (num.valid) begin
					head_q.column <= num.cell_column;
					head_q.row    <= num.cell_row;
					head_q.neg    <= num.value[31];
					mag_q         <= num.value[31] ? 32'(~num.value + 32'sd1) : num.value;
					cnt_q         <= '0;
				end
			end
			FR_MUL: begin
				prod_q <= {32'd0, mag_q} * {32'd0, RECIP10};
			end
			FR_DIV: begin
				digits_q[cnt_q[IW-1:0]] <= rem[3:0];
				cnt_q                   <= cnt_q + CW'(1);
				mag_q                   <= quo;
			end
			FR_PUSH: ;
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			digits_flat[4*i +: 4] = digits_q[i];
		end
	end

	assign job_data = {head_q, cnt_q, digits_flat};

	a_push_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_PUSH |-> cnt_q != '0)
		else $error("job handed off without digits");

	a_zero_quotient_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_DIV && quo == 32'd0 |=> state_q == FR_PUSH)
		else $error("conversion kept going after quotient reached zero");

endmodule

// ----- src/sdtp_queue.sv -----
// Short job queue between the converter and the character emitter.
// Depends on sdtp_pkg for the default depth.
`timescale 1ns / 1ps

module sdtp_queue import sdtp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             push, pop;

	assign push_ready = fill_q != NW'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NW'(DEPTH))
		else $error("queue fill count out of range");

endmodule

// ----- src/sdtp_back.sv -----
// Back part: walks a job and emits one placed character per transfer.
// Depends on sdtp_pkg and sdtp_out_if; takes jobs from the queue.
`timescale 1ns / 1ps

module sdtp_back import sdtp_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  logic [8+8+1+$clog2(MAX_DIGITS+1)+4*MAX_DIGITS-1:0] job_data,
	sdtp_out_if.source          chars
);

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int IW = $clog2(MAX_DIGITS);
	localparam int DW = 4 * MAX_DIGITS;

	back_state_t state_q, state_d;

	job_head_t        job_head;
	logic [CW-1:0]    job_cnt;
	logic [DW-1:0]    job_digits;

	logic [DW-1:0]    digits_q;
	logic [IW-1:0]    idx_q;
	logic             minus_q;
	logic [7:0]       col_q;
	logic [7:0]       row_q;
	logic [TOTAL_W-1:0] total_q;

	logic             out_valid_q;
	logic [6:0]       char_q;
	logic [7:0]       out_col_q;
	logic [7:0]       out_row_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic             visible_q;
	logic             last_q;

	logic             advance;
	logic             final_char;

	assign {job_head, job_cnt, job_digits} = job_data;

	assign advance    = state_q == BK_RUN && (!out_valid_q || chars.ready);
	assign final_char = !minus_q && idx_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (advance && final_char) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) begin
			digits_q <= job_digits;
			idx_q    <= IW'(job_cnt - CW'(1));
			minus_q  <= job_head.neg;
			col_q    <= job_head.column;
			row_q    <= job_head.row;
			total_q  <= TOTAL_W'(job_cnt) + TOTAL_W'(job_head.neg);
		end else if (advance) begin
			out_col_q   <= col_q;
			out_row_q   <= row_q;
			out_total_q <= total_q;
			visible_q   <= col_q[7:4] == 4'd0 && row_q[7:3] == 5'd0;
			col_q       <= col_q + 8'd1;
			last_q      <= final_char;
			if (minus_q) begin
				char_q  <= CHAR_MINUS;
				minus_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + {3'b000, digits_q[4*idx_q +: 4]};
				if (idx_q != '0) begin
					idx_q <= idx_q - IW'(1);
				end
			end
		end
	end

	assign chars.valid        = out_valid_q;
	assign chars.char_code    = char_q;
	assign chars.out_column   = out_col_q;
	assign chars.out_row      = out_row_q;
	assign chars.visible      = visible_q;
	assign chars.total_length = out_total_q;
	assign chars.last         = last_q;

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && char_q == CHAR_MINUS |-> !last_q && out_total_q >= TOTAL_W'(2))
		else $error("minus sign marked as final character");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && chars.ready && !last_q |-> state_q == BK_RUN)
		else $error("emitter left a run before its final character");

endmodule

// ----- src/signed_decimal_text_placer_unit.sv -----
// Converts a signed 32-bit number into placed decimal ASCII characters, one per
// output transfer, most significant first, with a leading minus for negative
// values. The front converter takes a reciprocal multiply step and a remainder
// step per decimal digit, plus an accept state and a handoff state; the back
// emitter sends one character per cycle within a number while the receiver is
// ready, 1 to 11 characters per number. A two-entry job queue lets the converter
// work on the next number while characters of the previous one go out.
// Depends on sdtp_pkg, sdtp_if, sdtp_front, sdtp_queue and sdtp_back.
`timescale 1ns / 1ps

module signed_decimal_text_placer_unit import sdtp_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	sdtp_in_if.sink    num,
	sdtp_out_if.source chars
);

	localparam int CW    = $clog2(MAX_DIGITS + 1);
	localparam int JOB_W = 8 + 8 + 1 + CW + 4 * MAX_DIGITS;

	logic             fq_valid, fq_ready;
	logic [JOB_W-1:0] fq_data;
	logic             qb_valid, qb_ready;
	logic [JOB_W-1:0] qb_data;

	sdtp_front #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job_data  (fq_data)
	);

	sdtp_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	sdtp_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job_data  (qb_data),
		.chars     (chars)
	);

endmodule

// ----- tb/sv/sdtp_char_checker.sv -----
// Watches the number and character channels of the signed decimal text placer.
// Predicts the placed characters of every number transfer and compares them in order.
// Depends on sdtp_pkg and sdtp_if.
`timescale 1ns / 1ps

module sdtp_char_checker import sdtp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sdtp_in_if   num,
	sdtp_out_if  chars,
	output int   mismatches,
	output int   outstanding
);

	localparam int         DIGIT_SLOTS         = 10;
	localparam logic [7:0] LAST_VISIBLE_COLUMN = 8'd15;
	localparam logic [7:0] LAST_VISIBLE_ROW    = 8'd7;
	localparam int         REPORT_LIMIT        = 40;

	typedef struct packed {
		logic [6:0] code;
		logic [7:0] column;
		logic [7:0] row;
		logic       visible;
		logic [3:0] total;
		logic       last;
	} placed_char_t;

	placed_char_t expected_chars[$];
	placed_char_t oldest;

	function automatic placed_char_t place_one(input logic [6:0] code, input logic [7:0] column,
		input logic [7:0] row, input logic [3:0] total, input logic last);
		placed_char_t pc;
		pc.code    = code;
		pc.column  = column;
		pc.row     = row;
		pc.visible = (column <= LAST_VISIBLE_COLUMN) && (row <= LAST_VISIBLE_ROW);
		pc.total   = total;
		pc.last    = last;
		return pc;
	endfunction

	function automatic void place_number(input logic [7:0] start_column, input logic [7:0] row,
		input logic [31:0] value);
		logic [31:0] magnitude;
		logic [3:0]  digits [0:DIGIT_SLOTS-1];
		int          ndigits;
		logic        neg;
		logic [7:0]  column;
		logic [3:0]  total;
		neg       = value[31];
		magnitude = neg ? (~value + 32'd1) : value;
		ndigits   = 0;
		if (magnitude == 32'd0) begin
			digits[0] = 4'd0;
			ndigits   = 1;
		end
		while (magnitude != 32'd0 && ndigits < DIGIT_SLOTS) begin
			digits[ndigits] = 4'(magnitude % 32'd10);
			magnitude       = magnitude / 32'd10;
			ndigits++;
		end
		total  = 4'(ndigits) + (neg ? 4'd1 : 4'd0);
		column = start_column;
		if (neg) begin
			expected_chars.push_back(place_one(CHAR_MINUS, column, row, total, 1'b0));
			column = column + 8'd1;
		end
		for (int i = ndigits - 1; i >= 0; i--) begin
			expected_chars.push_back(place_one(CHAR_ZERO + 7'(digits[i]), column, row, total,
				i == 0));
			column = column + 8'd1;
		end
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			mismatches = 0;
		end else begin
			if (num.valid && num.ready)
				place_number(num.cell_column, num.cell_row, num.value);
			if (chars.valid && chars.ready) begin
				if (expected_chars.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: expected no character, got code %0d at column %0d",
							$time, chars.char_code, chars.out_column);
					mismatches++;
				end else begin
					oldest = expected_chars.pop_front();
					check_field("char_code", 8'(oldest.code), 8'(chars.char_code));
					check_field("out_column", oldest.column, chars.out_column);
					check_field("out_row", oldest.row, chars.out_row);
					check_field("visible", 8'(oldest.visible), 8'(chars.visible));
					check_field("total_length", 8'(oldest.total), 8'(chars.total_length));
					check_field("last", 8'(oldest.last), 8'(chars.last));
				end
			end
		end
		outstanding = expected_chars.size();
	end

endmodule

// ----- tb/sv/tb_signed_decimal_text_placer_unit.sv -----
// Top of the signed decimal text placer testbench: clock, reset, number stimulus,
// character back-pressure, watchdog and verdict.
// Depends on sdtp_pkg, sdtp_if, signed_decimal_text_placer_unit and sdtp_char_checker.
`timescale 1ns / 1ps

module tb_signed_decimal_text_placer_unit import sdtp_pkg::*;;

	localparam int ITEMS_PER_PHASE = 50;
	localparam int PRESSURE_ITEMS  = 20;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT  = 3000;

	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_t;

	logic  clk;
	logic  arst_n;
	flow_t traffic;
	bit    hold_go;
	bit    hold_done;
	int    hold_left;
	int    quiet_cycles;
	int    mismatch_count;
	int    pending_chars;

	sdtp_in_if  num();
	sdtp_out_if chars();

	signed_decimal_text_placer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.chars  (chars)
	);

	sdtp_char_checker u_char_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.num         (num),
		.chars       (chars),
		.mismatches  (mismatch_count),
		.outstanding (pending_chars)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int sender_gap_pct(input flow_t f);
		case (f)
			FLOW_SENDER_GAPS: return 79;
			FLOW_BOTH:        return 13;
			default:          return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input flow_t f);
		case (f)
			FLOW_RECEIVER_STALLS: return 79;
			FLOW_BOTH:            return 13;
			default:              return 0;
		endcase
	endfunction

	function automatic logic [7:0] random_column();
		case ($urandom_range(0, 2))
			0:       return 8'($urandom_range(0, 255));
			1:       return 8'($urandom_range(0, 15));
			default: return 8'($urandom_range(240, 255));
		endcase
	endfunction

	function automatic logic [7:0] random_row();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] random_value();
		logic [31:0] v;
		logic [31:0] p;
		int          k;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(0, 31);
			2: begin
				k = $urandom_range(0, 9);
				p = 32'd1;
				repeat (k) p = p * 32'd10;
				v = p + 32'($urandom_range(0, 2)) - 32'd1;
			end
			3: v = 32'($urandom_range(0, 99));
			default: begin
				case ($urandom_range(0, 4))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7fff_ffff;
					2:       v = 32'h8000_0001;
					3:       v = 32'hffff_ffff;
					default: v = 32'd0;
				endcase
				return v;
			end
		endcase
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic send_number(input logic [7:0] column, input logic [7:0] row,
		input logic [31:0] value);
		while ($urandom_range(0, 99) < sender_gap_pct(traffic)) begin
			num.valid = 1'b0;
			@(negedge clk);
		end
		num.valid       = 1'b1;
		num.cell_column = column;
		num.cell_row    = row;
		num.value       = value;
		do @(posedge clk); while (!num.ready);
		@(negedge clk);
	endtask

	initial begin
		chars.ready = 1'b0;
		hold_left   = 0;
		hold_done   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				chars.ready = 1'b0;
				hold_left--;
			end else begin
				chars.ready = ($urandom_range(0, 99) >= receiver_stall_pct(traffic));
			end
		end
	end

	always @(posedge clk) begin
		if ((num.valid && num.ready) || (chars.valid && chars.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("signed_decimal_text_placer_unit: mismatch");
			$finish;
		end
	end

	initial begin
		quiet_cycles    = 0;
		traffic         = FLOW_FREE;
		hold_go         = 1'b0;
		num.valid       = 1'b0;
		num.cell_column = 8'd0;
		num.cell_row    = 8'd0;
		num.value       = 32'sd0;
		arst_n          = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send_number(8'd0, 8'd0, 32'd0);
		send_number(8'd0, 8'd0, 32'd1);
		send_number(8'd0, 8'd0, 32'hffff_ffff);
		send_number(8'd15, 8'd7, 32'h7fff_ffff);
		send_number(8'd250, 8'd7, 32'h8000_0000);
		send_number(8'd255, 8'd8, 32'h8000_0001);
		send_number(8'd16, 8'd0, 32'd9);
		send_number(8'd5, 8'd255, 32'd10);
		send_number(8'd0, 8'd7, -32'd10);
		send_number(8'd12, 8'd0, 32'd999_999_999);
		send_number(8'd0, 8'd0, 32'd1_000_000_000);
		send_number(8'd3, 8'd3, -32'd1_000_000_000);
		send_number(8'd255, 8'd255, 32'h8000_0000);
		send_number(8'd248, 8'd0, 32'd1_234_567_890);
		send_number(8'd14, 8'd6, -32'd99);
		send_number(8'd170, 8'd85, 32'h5555_5555);
		send_number(8'd85, 8'd170, 32'haaaa_aaaa);

		for (int ph = 0; ph < 4; ph++) begin
			traffic = flow_t'(ph);
			repeat (ITEMS_PER_PHASE) send_number(random_column(), random_row(), random_value());
		end

		// hold the character side off while numbers keep coming
		traffic = FLOW_FREE;
		hold_go = 1'b1;
		repeat (PRESSURE_ITEMS) send_number(random_column(), random_row(), random_value());
		num.valid = 1'b0;

		while (pending_chars != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_chars == 0)
			$display("signed_decimal_text_placer_unit: match");
		else
			$display("signed_decimal_text_placer_unit: mismatch");
		$finish;
	end

endmodule
